>>> hw/rtl/dual_stack_shared_array_core_defines.svh
// Assertion macros shared by the checker of the dual stack core.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef DUAL_STACK_SHARED_ARRAY_CORE_DEFINES_SVH
`define DUAL_STACK_SHARED_ARRAY_CORE_DEFINES_SVH

// Checked on every edge once reset is released.
`define DSSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define DSSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/dssa_pkg.sv
// Shared types and constants of the dual stack core.
// No dependencies.
package dssa_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 5;
  localparam int REM_W         = $clog2(MAX_RESULTS + 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_DUMP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    BACK_IDLE = 1'b0,
    BACK_READ = 1'b1
  } back_state_e;

  // one decoded transaction as it sits in the queue
  typedef struct packed {
    op_e               op;
    logic              sel;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // one result as it leaves the back end
  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } res_t;

endpackage

>>> hw/rtl/dual_stack_shared_array_core.sv
// Two stacks in one shared RAM: the lower grows up, the upper grows down.
// Push, clear and refused operations: result via the queue entry and result register.
// Pop and dump also pass the registered RAM read and hold the back end until done.
// Unstalled, push/clear/refused results and dump entries come one per cycle.
// A two-entry queue separates the input side from the executing back end.
// Reset clears both stack counts and all handshake state; RAM contents stay undefined.
module dual_stack_shared_array_core #(
  parameter int DEPTH = dssa_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [dssa_pkg::FUNC_W-1:0]          func_i,
  input  logic                                 stack_sel_i,
  input  logic signed [dssa_pkg::DATA_W-1:0]   push_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [dssa_pkg::STATUS_W-1:0]        status_o,
  output logic signed [dssa_pkg::DATA_W-1:0]   data_value_o,
  output logic [dssa_pkg::OCC_W-1:0]           occupancy_o,
  output logic                                 last_o
);

  logic           cmd_valid, cmd_pop;
  dssa_pkg::cmd_t cmd;
  dssa_pkg::res_t res;

  dssa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .stack_sel_i  (stack_sel_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  dssa_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_stall_i (out_stall_i)
  );

  // result fields onto the ports
  assign status_o     = res.status;
  assign data_value_o = res.data;
  assign occupancy_o  = res.occ;
  assign last_o       = res.last;

endmodule

>>> hw/rtl/dssa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port; read data holds until next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dssa_front.sv
// Front end: accepts input transactions, decodes the operation and queues them.
// Depends on dssa_pkg.
module dssa_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dssa_pkg::FUNC_W-1:0]        func_i,
  input  logic                               stack_sel_i,
  input  logic signed [dssa_pkg::DATA_W-1:0] push_value_i,
  output logic                               cmd_valid_o,
  output dssa_pkg::cmd_t                     cmd_o,
  input  logic                               cmd_pop_i
);

  dssa_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, full;
  dssa_pkg::cmd_t cmd_in;

  // classify the incoming transaction
  always_comb begin
    cmd_in.op    = dssa_pkg::op_e'(func_i);
    cmd_in.sel   = stack_sel_i;
    cmd_in.value = push_value_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign in_stall_o  = full;
  assign push        = in_valid_i && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> hw/rtl/dssa_back.sv
// Back end: stack pointers, shared entry RAM, dump walker and result register.
// Depends on dssa_pkg and dssa_ram.
module dssa_back #(
  parameter int DEPTH = dssa_pkg::DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  dssa_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  output dssa_pkg::res_t res_o,
  input  logic           res_stall_i
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int RW = dssa_pkg::REM_W;
  localparam int NW = (CW > RW) ? CW : RW;

  dssa_pkg::back_state_e state_q, state_d;
  logic [CW-1:0] lower_q, lower_d, upper_q, upper_d;
  logic [AW-1:0] addr_q, addr_d, addr_step;
  logic [RW-1:0] rem_q, rem_d;
  logic          dir_q, dir_d;
  logic          res_valid_q;
  dssa_pkg::res_t res_q, res_d;
  logic          res_load, out_free;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [dssa_pkg::DATA_W-1:0] rdata;

  logic [CW:0]   occ_now, occ_next;
  logic          full;
  logic [CW-1:0] lower_m1, upper_top, upper_push, n_sel;
  logic [AW-1:0] top_addr;
  logic [RW-1:0] n_cap;

  dssa_ram #(
    .WIDTH(dssa_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // pointer arithmetic
  assign occ_now    = {1'b0, lower_q} + {1'b0, upper_q};
  assign occ_next   = {1'b0, lower_d} + {1'b0, upper_d};
  assign full       = (occ_now >= (CW + 1)'(DEPTH));
  assign lower_m1   = lower_q - CW'(1);
  assign upper_top  = CW'(DEPTH) - upper_q;
  assign upper_push = upper_top - CW'(1);
  assign top_addr   = cmd_i.sel ? upper_top[AW-1:0] : lower_m1[AW-1:0];
  assign n_sel      = cmd_i.sel ? upper_q : lower_q;
  assign n_cap      = (NW'(n_sel) > NW'(dssa_pkg::MAX_RESULTS)) ?
                      RW'(dssa_pkg::MAX_RESULTS) : RW'(n_sel);
  assign addr_step  = dir_q ? (addr_q + AW'(1)) : (addr_q - AW'(1));
  assign out_free   = !res_valid_q || !res_stall_i;

  // sequencer: one transaction at a time, dump walks one entry per cycle while the output is free
  always_comb begin
    state_d    = state_q;
    lower_d    = lower_q;
    upper_d    = upper_q;
    addr_d     = addr_q;
    rem_d      = rem_q;
    dir_d      = dir_q;
    cmd_pop_o  = 1'b0;
    we         = 1'b0;
    waddr      = cmd_i.sel ? upper_push[AW-1:0] : lower_q[AW-1:0];
    re         = 1'b0;
    raddr      = top_addr;
    res_load   = 1'b0;
    res_d      = res_q;

    unique case (state_q)
      dssa_pkg::BACK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o   = 1'b1;
          res_load    = 1'b1;
          res_d.status = dssa_pkg::STATUS_OK;
          res_d.data   = '0;
          res_d.last   = 1'b1;
          unique case (cmd_i.op)
            dssa_pkg::OP_PUSH: begin
              if (full) begin
                res_d.status = dssa_pkg::STATUS_FULL;
              end else begin
                we = 1'b1;
                if (cmd_i.sel) begin
                  upper_d = upper_q + CW'(1);
                end else begin
                  lower_d = lower_q + CW'(1);
                end
              end
            end
            dssa_pkg::OP_POP, dssa_pkg::OP_DUMP: begin
              if (n_sel == '0) begin
                res_d.status = dssa_pkg::STATUS_EMPTY;
              end else begin
                // result is loaded with the read data in the read state
                res_load = 1'b0;
                re       = 1'b1;
                addr_d   = top_addr;
                dir_d    = cmd_i.sel;
                state_d  = dssa_pkg::BACK_READ;
                if (cmd_i.op == dssa_pkg::OP_POP) begin
                  rem_d = RW'(1);
                  if (cmd_i.sel) begin
                    upper_d = upper_q - CW'(1);
                  end else begin
                    lower_d = lower_m1;
                  end
                end else begin
                  rem_d = n_cap;
                end
              end
            end
            dssa_pkg::OP_CLEAR: begin
              lower_d = '0;
              upper_d = '0;
            end
          endcase
        end
      end
      dssa_pkg::BACK_READ: begin
        if (out_free) begin
          res_load     = 1'b1;
          res_d.status = dssa_pkg::STATUS_OK;
          res_d.data   = rdata;
          res_d.last   = (rem_q == RW'(1));
          if (rem_q == RW'(1)) begin
            state_d = dssa_pkg::BACK_IDLE;
          end else begin
            rem_d  = rem_q - RW'(1);
            addr_d = addr_step;
            re     = 1'b1;
            raddr  = addr_step;
          end
        end
      end
      default: begin
        state_d = dssa_pkg::BACK_IDLE;
      end
    endcase
    res_d.occ = dssa_pkg::OCC_W'(occ_next);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dssa_pkg::BACK_IDLE;
      lower_q     <= '0;
      upper_q     <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lower_q <= lower_d;
      upper_q <= upper_d;
      rem_q   <= rem_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    dir_q  <= dir_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/dssa_checker.sv
// Port-level checks of the dual stack core, bound to the top level.
// Depends on dssa_pkg and dual_stack_shared_array_core_defines.svh.
`include "dual_stack_shared_array_core_defines.svh"

module dssa_checker #(
  parameter int DEPTH = dssa_pkg::DEPTH_DEFAULT
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [dssa_pkg::STATUS_W-1:0]      status_o,
  input logic signed [dssa_pkg::DATA_W-1:0] data_value_o,
  input logic [dssa_pkg::OCC_W-1:0]         occupancy_o,
  input logic                               last_o
);

  // a stalled result transaction holds
  `DSSA_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_value_o) &&
    $stable(status_o) && $stable(last_o) && $stable(occupancy_o),
    "stalled result changed")

  // no result while in reset
  `DSSA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

  // a refused push means the shared array is full
  `DSSA_ASSERT(a_full_occ,
    out_valid_o && status_o == dssa_pkg::STATUS_FULL |->
    occupancy_o == dssa_pkg::OCC_W'(DEPTH) && data_value_o == 0 && last_o,
    "full status with wrong occupancy")

  // a dump keeps streaming: the next entry follows at once, occupancy unchanged
  `DSSA_ASSERT(a_dump_stream,
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o &&
    status_o == dssa_pkg::STATUS_OK && occupancy_o == $past(occupancy_o),
    "dump stream broken")

endmodule

bind dual_stack_shared_array_core dssa_checker #(
  .DEPTH(DEPTH)
) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .data_value_o (data_value_o),
  .occupancy_o  (occupancy_o),
  .last_o       (last_o)
);
